// ===== sv/edlp_pkg.sv =====
`default_nettype none

package edlp_pkg;

    // field widths of the link and host items
    localparam int REQ_W  = 3;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 6;

    // command and response bytes on the engine link
    localparam logic [BYTE_W-1:0] CMD_LOG    = 8'd16;
    localparam logic [BYTE_W-1:0] CMD_POLL   = 8'd32;
    localparam logic [BYTE_W-1:0] CMD_CLEAR  = 8'd80;
    localparam logic [BYTE_W-1:0] RESP_READY = 8'd205;
    localparam logic [BYTE_W-1:0] READ_NONE  = 8'hFF;

    // configuration register reset values
    localparam logic [7:0]  TIMEOUT_RST  = 8'd60;
    localparam logic [15:0] INTERVAL_RST = 16'd100;

    // register select, taken from paddr[2]
    localparam logic REG_TIMEOUT  = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 3'd0,
        REQ_RX    = 3'd1,
        REQ_READ  = 3'd2,
        REQ_CLEAR = 3'd3,
        REQ_START = 3'd4,
        REQ_STOP  = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_INTERVAL  = 2'd1,
        PH_HANDSHAKE = 2'd2,
        PH_PACKET    = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0]  timeout;
        logic [15:0] interval;
    } t_cfg;

    // write and read requests toward the packet store
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } t_store_req;

    // result of one step, read byte still to be merged
    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_data;
        logic              rd_req;
        logic              rd_hit;
        logic              link_connected;
        logic              packet_ok;
        logic              packet_done;
        logic              clear_done;
        logic              clear_ok;
    } t_step_res;

    // complete result item
    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_data;
        logic [BYTE_W-1:0] read_data;
        logic              link_connected;
        logic              packet_ok;
        logic              packet_done;
        logic              clear_done;
        logic              clear_ok;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/ecu_datalog_poll_controller_core.sv =====
// path: the result of an accepted item passes the step result register, then the output slot that offers it
// throughput: one item per cycle while o_in_stall stays low; state, the packet store port and the result
//   register all advance together on each transfer
// reset: synchronous active-low i_rst_n clears phase, flags, counters and
//   restores the timeout and interval registers; the packet store is not cleared
`default_nettype none

module ecu_datalog_poll_controller_core #(
    parameter int PACKET_BYTES = 52
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [7:0]  i_rx_data,
    input  wire logic [5:0]  i_param_index,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_tx_valid,
    output logic [7:0]       o_tx_data,
    output logic [7:0]       o_read_data,
    output logic             o_link_connected,
    output logic             o_packet_ok,
    output logic             o_packet_done,
    output logic             o_clear_done,
    output logic             o_clear_ok
);
    import edlp_pkg::*;

    t_cfg       cfg;
    t_store_req store_req;
    logic [7:0] store_q;
    logic       push, push_ready;
    t_step_res  step_res;
    t_result    res_in, res_out;

    edlp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    edlp_step #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_rx_data     (i_rx_data),
        .i_param_index (i_param_index),
        .o_store       (store_req),
        .o_push        (push),
        .i_push_ready  (push_ready),
        .o_res         (step_res)
    );

    edlp_store #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (store_q)
    );

    // merge the stored byte into the result
    always_comb begin
        res_in.tx_valid       = step_res.tx_valid;
        res_in.tx_data        = step_res.tx_data;
        res_in.link_connected = step_res.link_connected;
        res_in.packet_ok      = step_res.packet_ok;
        res_in.packet_done    = step_res.packet_done;
        res_in.clear_done     = step_res.clear_done;
        res_in.clear_ok       = step_res.clear_ok;
        if (step_res.rd_hit) begin
            res_in.read_data = store_q;
        end else if (step_res.rd_req) begin
            res_in.read_data = READ_NONE;
        end else begin
            res_in.read_data = '0;
        end
    end

    edlp_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res_in),
        .o_ready (push_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (res_out)
    );

    assign o_tx_valid       = res_out.tx_valid;
    assign o_tx_data        = res_out.tx_data;
    assign o_read_data      = res_out.read_data;
    assign o_link_connected = res_out.link_connected;
    assign o_packet_ok      = res_out.packet_ok;
    assign o_packet_done    = res_out.packet_done;
    assign o_clear_done     = res_out.clear_done;
    assign o_clear_ok       = res_out.clear_ok;

endmodule

`default_nettype wire

// ===== sv/edlp_regs.sv =====
`default_nettype none

module edlp_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output edlp_pkg::t_cfg    o_cfg
);
    import edlp_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // register write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout  <= TIMEOUT_RST;
            r_cfg.interval <= INTERVAL_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TIMEOUT:  r_cfg.timeout  <= pwdata[7:0];
                REG_INTERVAL: r_cfg.interval <= pwdata[15:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            REG_TIMEOUT:  prdata = {24'd0, r_cfg.timeout};
            REG_INTERVAL: prdata = {16'd0, r_cfg.interval};
            default:      prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/edlp_store.sv =====
`default_nettype none

module edlp_store #(
    parameter int PACKET_BYTES = 52
) (
    input  wire logic                  i_clk,
    input  wire edlp_pkg::t_store_req  i_req,
    output logic [7:0]                 o_rd_data
);
    import edlp_pkg::*;

    localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

    logic [BYTE_W-1:0] mem [PACKET_BYTES];
    logic [BYTE_W-1:0] r_q;

    // packet byte write
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_q <= mem[i_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_q;

endmodule

`default_nettype wire

// ===== sv/edlp_step.sv =====
`default_nettype none

module edlp_step #(
    parameter int PACKET_BYTES = 52
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire edlp_pkg::t_cfg        i_cfg,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [2:0]            i_req_type,
    input  wire logic [7:0]            i_rx_data,
    input  wire logic [5:0]            i_param_index,
    output edlp_pkg::t_store_req       o_store,
    output logic                       o_push,
    input  wire logic                  i_push_ready,
    output edlp_pkg::t_step_res        o_res
);
    import edlp_pkg::*;

    localparam int CW = $clog2(PACKET_BYTES + 1);
    localparam logic [CW-1:0]    LAST_BYTE = CW'(PACKET_BYTES - 1);
    localparam logic [IDX_W:0]   NB        = (IDX_W + 1)'(PACKET_BYTES);

    // control state
    t_phase        r_phase, n_phase;
    logic          r_polling, n_polling;
    logic          r_logging, n_logging;
    logic          r_pvalid, n_pvalid;
    logic          r_conn, n_conn;
    logic          r_cpend, n_cpend;
    logic [CW-1:0] r_bcount, n_bcount;
    logic [7:0]    r_wait, n_wait;
    logic [15:0]   r_poll, n_poll;

    // result register
    logic          r_res_vld;
    t_step_res     r_res, n_res;

    logic          advance;
    logic          accept;
    logic          end_hs, end_pk, end_ok, start_hs, start_pk;
    logic          idx_in_range;

    assign advance    = !r_res_vld || i_push_ready;
    assign accept     = i_in_valid && advance;
    assign o_in_stall = !advance;
    assign o_push     = r_res_vld && i_push_ready;
    assign o_res      = r_res;

    assign idx_in_range = {1'b0, i_param_index} < NB;

    // next state and result of one step
    always_comb begin
        n_phase   = r_phase;
        n_polling = r_polling;
        n_logging = r_logging;
        n_pvalid  = r_pvalid;
        n_conn    = r_conn;
        n_cpend   = r_cpend;
        n_bcount  = r_bcount;
        n_wait    = r_wait;
        n_poll    = r_poll;
        n_res     = '0;
        end_hs    = 1'b0;
        end_pk    = 1'b0;
        end_ok    = 1'b0;
        start_hs  = 1'b0;
        start_pk  = 1'b0;
        o_store         = '0;
        o_store.wr_addr = IDX_W'(r_bcount);
        o_store.wr_data = i_rx_data;
        o_store.rd_addr = i_param_index;

        unique case (i_req_type)
            REQ_TICK: begin
                if (r_polling && r_poll != 16'hFFFF) begin
                    n_poll = r_poll + 16'd1;
                end
                if (r_phase == PH_HANDSHAKE || r_phase == PH_PACKET) begin
                    if (r_wait >= i_cfg.timeout) begin
                        end_hs = (r_phase == PH_HANDSHAKE);
                        end_pk = (r_phase == PH_PACKET);
                    end else begin
                        n_wait = r_wait + 8'd1;
                    end
                end else if (r_phase == PH_INTERVAL && n_poll >= i_cfg.interval) begin
                    n_poll   = '0;
                    start_pk = r_logging;
                    start_hs = !r_logging;
                end
            end
            REQ_RX: begin
                if (r_phase == PH_HANDSHAKE) begin
                    end_hs = 1'b1;
                    end_ok = (i_rx_data == RESP_READY);
                end else if (r_phase == PH_PACKET) begin
                    o_store.wr_en = accept;
                    n_bcount      = r_bcount + CW'(1);
                    n_wait        = '0;
                    if (r_bcount == LAST_BYTE) begin
                        end_pk = 1'b1;
                        end_ok = 1'b1;
                    end
                end
            end
            REQ_READ: begin
                n_res.rd_req  = 1'b1;
                n_res.rd_hit  = r_pvalid && idx_in_range;
                o_store.rd_en = accept && r_pvalid && idx_in_range;
            end
            REQ_CLEAR: begin
                if (r_phase == PH_HANDSHAKE || r_phase == PH_PACKET) begin
                    n_cpend = 1'b1;
                end else if (r_logging) begin
                    n_res.tx_valid   = 1'b1;
                    n_res.tx_data    = CMD_CLEAR;
                    n_res.clear_done = 1'b1;
                    n_res.clear_ok   = 1'b1;
                end else begin
                    n_cpend  = 1'b1;
                    start_hs = 1'b1;
                end
            end
            REQ_START: begin
                if (!r_polling) begin
                    n_polling = 1'b1;
                    n_poll    = '0;
                    if (r_phase == PH_IDLE) begin
                        start_pk = r_logging;
                        start_hs = !r_logging;
                    end
                end
            end
            REQ_STOP: begin
                if (r_cpend) begin
                    n_cpend          = 1'b0;
                    n_res.clear_done = 1'b1;
                end
                n_polling = 1'b0;
                n_logging = 1'b0;
                n_pvalid  = 1'b0;
                n_phase   = PH_IDLE;
                n_bcount  = '0;
                n_wait    = '0;
                n_poll    = '0;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        // handshake finished
        if (end_hs) begin
            n_logging = end_ok;
            if (r_polling) begin
                n_conn   = end_ok;
                n_pvalid = 1'b0;
            end
            if (r_cpend) begin
                n_cpend          = 1'b0;
                n_res.clear_done = 1'b1;
                if (end_ok) begin
                    n_res.tx_valid = 1'b1;
                    n_res.tx_data  = CMD_CLEAR;
                    n_res.clear_ok = 1'b1;
                end
            end
            n_phase = r_polling ? PH_INTERVAL : PH_IDLE;
        end

        // packet finished or timed out
        if (end_pk) begin
            n_pvalid  = end_ok;
            n_conn    = end_ok;
            n_logging = end_ok ? r_logging : 1'b0;
            n_res.packet_done = end_ok;
            n_phase   = r_polling ? PH_INTERVAL : PH_IDLE;
            if (r_cpend) begin
                if (n_logging) begin
                    n_cpend          = 1'b0;
                    n_res.tx_valid   = 1'b1;
                    n_res.tx_data    = CMD_CLEAR;
                    n_res.clear_done = 1'b1;
                    n_res.clear_ok   = 1'b1;
                end else begin
                    start_hs = 1'b1;
                end
            end
        end

        // new exchange
        if (start_hs) begin
            n_res.tx_valid = 1'b1;
            n_res.tx_data  = CMD_LOG;
            n_phase        = PH_HANDSHAKE;
            n_wait         = '0;
        end
        if (start_pk) begin
            n_res.tx_valid = 1'b1;
            n_res.tx_data  = CMD_POLL;
            n_phase        = PH_PACKET;
            n_bcount       = '0;
            n_wait         = '0;
        end

        n_res.link_connected = n_conn;
        n_res.packet_ok      = n_pvalid;
    end

    // state register, updated on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_polling <= 1'b0;
            r_logging <= 1'b0;
            r_pvalid  <= 1'b0;
            r_conn    <= 1'b0;
            r_cpend   <= 1'b0;
            r_bcount  <= '0;
            r_wait    <= '0;
            r_poll    <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_polling <= n_polling;
            r_logging <= n_logging;
            r_pvalid  <= n_pvalid;
            r_conn    <= n_conn;
            r_cpend   <= n_cpend;
            r_bcount  <= n_bcount;
            r_wait    <= n_wait;
            r_poll    <= n_poll;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (accept) begin
            r_res_vld <= 1'b1;
        end else if (o_push) begin
            r_res_vld <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ===== sv/edlp_outbuf.sv =====
`default_nettype none

module edlp_outbuf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire edlp_pkg::t_result  i_data,
    output logic                    o_ready,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output edlp_pkg::t_result       o_data
);
    import edlp_pkg::*;

    logic    r_a_vld, r_b_vld;
    t_result r_a, r_b;
    logic    pop;

    assign pop     = r_a_vld && !i_stall;
    assign o_ready = !r_b_vld;
    assign o_valid = r_a_vld;
    assign o_data  = r_a;

    // output slot and skid slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (r_b_vld) begin
            if (pop) begin
                r_b_vld <= 1'b0;
            end
        end else if (i_push) begin
            r_a_vld <= 1'b1;
            r_b_vld <= r_a_vld && !pop;
        end else if (pop) begin
            r_a_vld <= 1'b0;
        end
    end

    // payload moves
    always_ff @(posedge i_clk) begin
        if (r_b_vld) begin
            if (pop) begin
                r_a <= r_b;
            end
        end else if (i_push) begin
            if (!r_a_vld || pop) begin
                r_a <= i_data;
            end else begin
                r_b <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sim/ecu_datalog_poll_controller_core_tb.sv =====
module ecu_datalog_poll_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import edlp_pkg::*;

    localparam int PACKET_BYTES = 52;
    localparam int CYCLE_LIMIT = 2_000_000;

    // request codes the block leaves unused
    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;
    localparam logic [BYTE_W-1:0] NO_CMD = 8'd0;

    // register addresses, select bit in paddr[2]
    localparam logic [2:0] ADDR_TIMEOUT = {REG_TIMEOUT, 2'b00};
    localparam logic [2:0] ADDR_INTERVAL = {REG_INTERVAL, 2'b00};

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [2:0] i_req_type = '0;
    logic [7:0] i_rx_data = '0;
    logic [5:0] i_param_index = '0;

    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_tx_valid;
    logic [7:0] o_tx_data;
    logic [7:0] o_read_data;
    logic o_link_connected;
    logic o_packet_ok;
    logic o_packet_done;
    logic o_clear_done;
    logic o_clear_ok;

    ecu_datalog_poll_controller_core #(
        .PACKET_BYTES(PACKET_BYTES)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_req_type(i_req_type),
        .i_rx_data(i_rx_data),
        .i_param_index(i_param_index),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_tx_valid(o_tx_valid),
        .o_tx_data(o_tx_data),
        .o_read_data(o_read_data),
        .o_link_connected(o_link_connected),
        .o_packet_ok(o_packet_ok),
        .o_packet_done(o_packet_done),
        .o_clear_done(o_clear_done),
        .o_clear_ok(o_clear_ok)
    );

    // directed stimulus row with its expected result
    typedef struct {
        logic [REQ_W-1:0] req;
        logic [BYTE_W-1:0] rx;
        logic [IDX_W-1:0] idx;
        t_result res;
    } t_script_row;

    t_script_row script[$];
    t_result poll_results_due[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int idle_pct = 0;
    int stall_left = 0;
    bit quiet = 1'b0;

    // predicted controller state and configuration
    logic [7:0] cfg_timeout = TIMEOUT_RST;
    logic [15:0] cfg_interval = INTERVAL_RST;
    t_phase link_phase = PH_IDLE;
    logic poll_on = 1'b0;
    logic log_on = 1'b0;
    logic pkt_valid = 1'b0;
    logic conn = 1'b0;
    logic clr_pend = 1'b0;
    int rx_count = 0;
    logic [7:0] reply_wait = '0;
    logic [15:0] tick_count = '0;
    logic [7:0] pkt_bytes [PACKET_BYTES];
    t_result step_res;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL ecu_datalog_poll_controller_core");
            $finish;
        end
    end

    // result side stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(99) < idle_pct) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(5);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // command byte goes out on this step
    function automatic void issue(input logic [7:0] cmd);
        step_res.tx_valid = 1'b1;
        step_res.tx_data = cmd;
    endfunction

    function automatic void begin_handshake();
        issue(CMD_LOG);
        link_phase = PH_HANDSHAKE;
        reply_wait = '0;
    endfunction

    function automatic void begin_packet();
        issue(CMD_POLL);
        link_phase = PH_PACKET;
        rx_count = 0;
        reply_wait = '0;
    endfunction

    function automatic void settle_phase();
        link_phase = poll_on ? PH_INTERVAL : PH_IDLE;
    endfunction

    function automatic void finish_handshake(input logic ok);
        log_on = ok;
        if (poll_on) begin
            conn = ok;
            pkt_valid = 1'b0;
        end
        if (clr_pend) begin
            clr_pend = 1'b0;
            step_res.clear_done = 1'b1;
            if (ok) begin
                issue(CMD_CLEAR);
                step_res.clear_ok = 1'b1;
            end
        end
        settle_phase();
    endfunction

    function automatic void finish_packet(input logic ok);
        if (ok) begin
            pkt_valid = 1'b1;
            conn = 1'b1;
            step_res.packet_done = 1'b1;
        end else begin
            pkt_valid = 1'b0;
            conn = 1'b0;
            log_on = 1'b0;
        end
        settle_phase();
        // a held clear is served once the exchange is over
        if (clr_pend) begin
            if (log_on) begin
                clr_pend = 1'b0;
                issue(CMD_CLEAR);
                step_res.clear_done = 1'b1;
                step_res.clear_ok = 1'b1;
            end else begin
                begin_handshake();
            end
        end
    endfunction

    // expected result of one accepted request, advances the predicted state
    function automatic t_result poll_controller_step(input logic [2:0] req,
                                                     input logic [7:0] rx,
                                                     input logic [5:0] idx);
        step_res = '0;
        case (req)
            REQ_TICK: begin
                if (poll_on && tick_count != 16'hFFFF)
                    tick_count++;
                if (link_phase == PH_HANDSHAKE || link_phase == PH_PACKET) begin
                    if (reply_wait >= cfg_timeout) begin
                        if (link_phase == PH_HANDSHAKE)
                            finish_handshake(1'b0);
                        else
                            finish_packet(1'b0);
                    end else begin
                        reply_wait++;
                    end
                end else if (link_phase == PH_INTERVAL && tick_count >= cfg_interval) begin
                    tick_count = '0;
                    if (log_on)
                        begin_packet();
                    else
                        begin_handshake();
                end
            end
            REQ_RX: begin
                if (link_phase == PH_HANDSHAKE) begin
                    finish_handshake(rx == RESP_READY);
                end else if (link_phase == PH_PACKET) begin
                    if (rx_count < PACKET_BYTES)
                        pkt_bytes[rx_count] = rx;
                    rx_count++;
                    reply_wait = '0;
                    if (rx_count >= PACKET_BYTES)
                        finish_packet(1'b1);
                end
            end
            REQ_READ: begin
                step_res.read_data = (pkt_valid && idx < PACKET_BYTES) ?
                                     pkt_bytes[idx] : READ_NONE;
            end
            REQ_CLEAR: begin
                if (link_phase == PH_HANDSHAKE || link_phase == PH_PACKET) begin
                    clr_pend = 1'b1;
                end else if (log_on) begin
                    issue(CMD_CLEAR);
                    step_res.clear_done = 1'b1;
                    step_res.clear_ok = 1'b1;
                end else begin
                    clr_pend = 1'b1;
                    begin_handshake();
                end
            end
            REQ_START: begin
                if (!poll_on) begin
                    poll_on = 1'b1;
                    tick_count = '0;
                    if (link_phase == PH_IDLE) begin
                        if (log_on)
                            begin_packet();
                        else
                            begin_handshake();
                    end
                end
            end
            REQ_STOP: begin
                if (clr_pend) begin
                    clr_pend = 1'b0;
                    step_res.clear_done = 1'b1;
                end
                poll_on = 1'b0;
                log_on = 1'b0;
                pkt_valid = 1'b0;
                link_phase = PH_IDLE;
                rx_count = 0;
                reply_wait = '0;
                tick_count = '0;
            end
            default: ;
        endcase
        step_res.link_connected = conn;
        step_res.packet_ok = pkt_valid;
        return step_res;
    endfunction

    // result checker, a transfer happens at the next rising edge
    always @(negedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            got = {o_tx_valid, o_tx_data, o_read_data, o_link_connected, o_packet_ok,
                   o_packet_done, o_clear_done, o_clear_ok};
            if (poll_results_due.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = poll_results_due.pop_front();
                check_field("tx_valid", got.tx_valid, want.tx_valid);
                check_field("tx_data", got.tx_data, want.tx_data);
                check_field("read_data", got.read_data, want.read_data);
                check_field("link_connected", got.link_connected, want.link_connected);
                check_field("packet_ok", got.packet_ok, want.packet_ok);
                check_field("packet_done", got.packet_done, want.packet_done);
                check_field("clear_done", got.clear_done, want.clear_done);
                check_field("clear_ok", got.clear_ok, want.clear_ok);
            end
        end
    end

    // one request transfer, optionally against a fixed expectation
    task automatic transfer(input logic [2:0] req, input logic [7:0] rx,
                            input logic [5:0] idx, input bit fixed, input t_result fixed_res);
        int gap;
        t_result predicted;
        gap = (!quiet && $urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_rx_data <= rx;
        i_param_index <= idx;
        do @(negedge i_clk); while (o_in_stall !== 1'b0);
        @(posedge i_clk);
        predicted = poll_controller_step(req, rx, idx);
        poll_results_due.push_back(fixed ? fixed_res : predicted);
    endtask

    task automatic add_row(input logic [2:0] req, input logic [7:0] rx, input logic [5:0] idx,
                           input logic [7:0] tx, input logic [7:0] rd, input logic lc,
                           input logic cd, input logic co);
        t_script_row row;
        row.req = req;
        row.rx = rx;
        row.idx = idx;
        row.res = '0;
        row.res.tx_valid = (tx != NO_CMD);
        row.res.tx_data = tx;
        row.res.read_data = rd;
        row.res.link_connected = lc;
        row.res.clear_done = cd;
        row.res.clear_ok = co;
        script.push_back(row);
    endtask

    // register write followed by a read back
    task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (pready !== 1'b1);
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (pready !== 1'b1);
        got = prdata;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== value)
            report_mismatch($sformatf("register %0d reads %0d want %0d", addr, got, value));
        if (addr == ADDR_TIMEOUT)
            cfg_timeout = value[7:0];
        else
            cfg_interval = value[15:0];
    endtask

    // drain all results, then reprogram while nothing is in flight
    task automatic reconfigure(input logic [7:0] timeout_ms, input logic [15:0] interval_ms);
        i_in_valid <= 1'b0;
        while (poll_results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        set_register(ADDR_TIMEOUT, {24'd0, timeout_ms});
        set_register(ADDR_INTERVAL, {16'd0, interval_ms});
    endtask

    // next request, mostly what the current exchange wants to see
    function automatic void pick_request(input int noise_pct, input int tick_pct,
                                         output logic [2:0] req, output logic [7:0] rx,
                                         output logic [5:0] idx);
        int r;
        r = $urandom_range(99);
        rx = 8'($urandom);
        idx = 6'($urandom_range(63));
        if (r < noise_pct) begin
            req = 3'($urandom_range(7));
            if (req == REQ_STOP && $urandom_range(3) != 0)
                req = REQ_READ;
        end else begin
            r = $urandom_range(99);
            case (link_phase)
                PH_IDLE:
                    req = (r < 60) ? REQ_START : (r < 80) ? REQ_CLEAR : REQ_READ;
                PH_INTERVAL:
                    req = (r < 95) ? REQ_TICK : REQ_READ;
                PH_HANDSHAKE: begin
                    if (r < tick_pct) begin
                        req = REQ_TICK;
                    end else begin
                        r = $urandom_range(99);
                        req = (r < 92) ? REQ_RX : REQ_READ;
                        if (r < 80)
                            rx = RESP_READY;
                    end
                end
                default: begin
                    if (r < tick_pct) begin
                        req = REQ_TICK;
                    end else begin
                        r = $urandom_range(99);
                        req = (r < 92) ? REQ_RX : (r < 96) ? REQ_READ : REQ_CLEAR;
                    end
                end
            endcase
        end
    endfunction

    task automatic run_polling(input int items, input int noise_pct, input int tick_pct);
        logic [2:0] req;
        logic [7:0] rx;
        logic [5:0] idx;
        for (int n = 0; n < items; n++) begin
            if (n % 256 == 0 && !quiet)
                idle_pct = 15 * $urandom_range(2);
            pick_request(noise_pct, tick_pct, req, rx, idx);
            transfer(req, rx, idx, 1'b0, '0);
        end
    endtask

    initial begin
        // directed table: special cases with their results spelled out
        add_row(REQ_READ, 8'h00, 6'd0, NO_CMD, READ_NONE, 0, 0, 0);
        add_row(REQ_READ, 8'h00, 6'd63, NO_CMD, READ_NONE, 0, 0, 0);
        add_row(REQ_SPARE_A, 8'hFF, 6'd63, NO_CMD, 8'd0, 0, 0, 0);
        add_row(REQ_SPARE_B, 8'hFF, 6'd63, NO_CMD, 8'd0, 0, 0, 0);
        add_row(REQ_RX, 8'hFF, 6'd0, NO_CMD, 8'd0, 0, 0, 0);
        add_row(REQ_TICK, 8'h00, 6'd0, NO_CMD, 8'd0, 0, 0, 0);
        add_row(REQ_STOP, 8'h00, 6'd0, NO_CMD, 8'd0, 0, 0, 0);
        add_row(REQ_START, 8'h00, 6'd0, CMD_LOG, 8'd0, 0, 0, 0);
        add_row(REQ_START, 8'h00, 6'd0, NO_CMD, 8'd0, 0, 0, 0);
        add_row(REQ_RX, RESP_READY, 6'd0, NO_CMD, 8'd0, 1, 0, 0);
        add_row(REQ_READ, 8'h00, 6'd0, NO_CMD, READ_NONE, 1, 0, 0);
        add_row(REQ_CLEAR, 8'h00, 6'd0, CMD_CLEAR, 8'd0, 1, 1, 1);
        add_row(REQ_STOP, 8'h00, 6'd0, NO_CMD, 8'd0, 1, 0, 0);
        // clear from idle needs its own handshake; a second clear is dropped
        add_row(REQ_CLEAR, 8'h00, 6'd0, CMD_LOG, 8'd0, 1, 0, 0);
        add_row(REQ_CLEAR, 8'h00, 6'd0, NO_CMD, 8'd0, 1, 0, 0);
        add_row(REQ_START, 8'h00, 6'd0, NO_CMD, 8'd0, 1, 0, 0);
        add_row(REQ_RX, 8'h00, 6'd0, NO_CMD, 8'd0, 0, 1, 0);
        add_row(REQ_STOP, 8'h00, 6'd0, NO_CMD, 8'd0, 0, 0, 0);
        // stop abandons a clear handshake
        add_row(REQ_CLEAR, 8'h00, 6'd0, CMD_LOG, 8'd0, 0, 0, 0);
        add_row(REQ_STOP, 8'h00, 6'd0, NO_CMD, 8'd0, 0, 1, 0);
        add_row(REQ_START, 8'h00, 6'd0, CMD_LOG, 8'd0, 0, 0, 0);
        add_row(REQ_RX, RESP_READY, 6'd0, NO_CMD, 8'd0, 1, 0, 0);
        add_row(REQ_STOP, 8'h00, 6'd0, NO_CMD, 8'd0, 1, 0, 0);
        // clear handshake without polling, then start with logging already on
        add_row(REQ_CLEAR, 8'h00, 6'd0, CMD_LOG, 8'd0, 1, 0, 0);
        add_row(REQ_RX, RESP_READY, 6'd0, CMD_CLEAR, 8'd0, 1, 1, 1);
        add_row(REQ_START, 8'h00, 6'd0, CMD_POLL, 8'd0, 1, 0, 0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 20;
        foreach (script[k])
            transfer(script[k].req, script[k].rx, script[k].idx, 1'b1, script[k].res);

        // reset configuration
        run_polling(120, 8, 15);
        // timeout and interval of one
        reconfigure(8'd1, 16'd1);
        run_polling(80, 10, 30);
        reconfigure(8'd3, 16'd5);
        run_polling(80, 10, 45);
        // longest timeout and interval
        reconfigure(8'd255, 16'd65535);
        run_polling(60, 0, 40);
        // frequent reply timeouts
        reconfigure(8'd20, 16'd200);
        run_polling(80, 8, 90);
        // closing stretch at full rate
        quiet = 1'b1;
        idle_pct = 0;
        reconfigure(8'($urandom_range(1, 8)), 16'($urandom_range(1, 30)));
        run_polling(60, 10, 40);

        i_in_valid <= 1'b0;
        while (poll_results_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS ecu_datalog_poll_controller_core");
        else
            $display("FAIL ecu_datalog_poll_controller_core");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/edlp_pkg.sv
sv/edlp_regs.sv
sv/edlp_store.sv
sv/edlp_step.sv
sv/edlp_outbuf.sv
sv/ecu_datalog_poll_controller_core.sv
sim/ecu_datalog_poll_controller_core_tb.sv
